// ----- sv/rscc_pkg.sv -----
// ----------------------------------------------------------------------------
// rscc_pkg
// shared constants, codes, tables and control structs of the collision checker
// ----------------------------------------------------------------------------
package rscc_pkg;

    localparam int DEF_MAX_OBSTACLES = 64;
    localparam int DEF_COORD_BITS    = 32;

    localparam int SLOT_W    = 6;
    localparam int HEADING_W = 16;
    localparam int LEN_W     = 31;
    localparam int COUNT_W   = 7;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 4;
    // rotated body vector and angle accumulator widths
    localparam int DL_W = 34;
    localparam int Z_W  = 34;

    localparam logic [31:0] CORDIC_GAIN_Q32 = 32'h9B74_EDA8;

    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_LENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_COUNT = 8'd1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic KIND_WRITE_ACK = 1'b0;
    localparam logic KIND_QUERY     = 1'b1;

    typedef struct packed {
        logic              wr_en;
        logic              q_load;
        logic              cordic_init;
        logic              cordic_step;
        logic [STEP_W-1:0] step;
        logic              scan_issue;
    } rscc_cmd_t;

    typedef struct packed {
        logic              pipe_busy;
        logic              hit_found;
        logic [SLOT_W-1:0] hit_slot;
    } rscc_status_t;

    function automatic logic [31:0] cordic_atan(input logic [STEP_W-1:0] i);
        logic [31:0] a;
        case (i)
            4'd0:    a = 32'h2000_0000;
            4'd1:    a = 32'h12E4_051E;
            4'd2:    a = 32'h09FB_385B;
            4'd3:    a = 32'h0511_11D4;
            4'd4:    a = 32'h028B_0D43;
            4'd5:    a = 32'h0145_D7E1;
            4'd6:    a = 32'h00A2_F61E;
            4'd7:    a = 32'h0051_7C55;
            4'd8:    a = 32'h0028_BE53;
            4'd9:    a = 32'h0014_5F2F;
            4'd10:   a = 32'h000A_2F98;
            4'd11:   a = 32'h0005_17CC;
            4'd12:   a = 32'h0002_8BE6;
            4'd13:   a = 32'h0001_45F3;
            4'd14:   a = 32'h0000_A2FA;
            default: a = 32'h0000_517D;
        endcase
        return a;
    endfunction

endpackage

// ----- sv/rscc_ctrl.sv -----
// ----------------------------------------------------------------------------
// rscc_ctrl
// sequencer: accepts commands, steps the rotation, walks the table, holds result
// ----------------------------------------------------------------------------
module rscc_ctrl #(
    parameter int MAX_OBSTACLES = rscc_pkg::DEF_MAX_OBSTACLES,
    parameter int AW            = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1,
    parameter int CNT_W         = $clog2(MAX_OBSTACLES + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_cmd,
    input  logic [rscc_pkg::SLOT_W-1:0]   in_slot,
    input  logic [rscc_pkg::COUNT_W-1:0]  obstacle_count,
    output rscc_pkg::rscc_cmd_t           cmd,
    output logic [AW-1:0]                 scan_addr,
    input  rscc_pkg::rscc_status_t        status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_kind,
    output logic                          out_free,
    output logic [rscc_pkg::SLOT_W-1:0]   out_slot
);

    typedef enum logic [2:0] {
        S_IDLE, S_GAIN, S_ROTATE, S_SCAN, S_DRAIN, S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [rscc_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic                            kind_reg, kind_next;
    logic                            ovalid_reg, ovalid_next;
    logic                            okind_reg, okind_next;
    logic                            ofree_reg, ofree_next;
    logic [rscc_pkg::SLOT_W-1:0]     oslot_reg, oslot_next;
    logic [CNT_W-1:0]                n_sat;
    logic                            accept;

    assign n_sat = (int'(obstacle_count) > MAX_OBSTACLES) ? CNT_W'(MAX_OBSTACLES)
                                                          : CNT_W'(obstacle_count);
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign scan_addr = cnt_reg[AW-1:0];

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        cnt_next    = cnt_reg;
        kind_next   = kind_reg;
        ovalid_next = ovalid_reg && !out_ready;
        okind_next  = okind_reg;
        ofree_next  = ofree_reg;
        oslot_next  = oslot_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (in_cmd == rscc_pkg::CMD_WRITE) begin
                        cmd.wr_en  = (int'(in_slot) < MAX_OBSTACLES);
                        kind_next  = rscc_pkg::KIND_WRITE_ACK;
                        state_next = S_DONE;
                    end else begin
                        cmd.q_load = 1'b1;
                        kind_next  = rscc_pkg::KIND_QUERY;
                        state_next = S_GAIN;
                    end
                end
            end
            S_GAIN: begin
                cmd.cordic_init = 1'b1;
                step_next       = '0;
                state_next      = S_ROTATE;
            end
            S_ROTATE: begin
                cmd.cordic_step = 1'b1;
                cmd.step        = step_reg;
                step_next       = step_reg + 1'b1;
                if (step_reg == rscc_pkg::STEP_W'(rscc_pkg::CORDIC_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (cnt_reg == n_sat) begin
                    state_next = S_DRAIN;
                end else begin
                    cmd.scan_issue = 1'b1;
                    cnt_next       = cnt_reg + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!ovalid_reg || out_ready) begin
                    ovalid_next = 1'b1;
                    okind_next  = kind_reg;
                    ofree_next  = (kind_reg == rscc_pkg::KIND_QUERY) && !status.hit_found;
                    oslot_next  = ((kind_reg == rscc_pkg::KIND_QUERY) && status.hit_found)
                                  ? status.hit_slot : '0;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            step_reg   <= '0;
            cnt_reg    <= '0;
            kind_reg   <= rscc_pkg::KIND_WRITE_ACK;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            step_reg   <= step_next;
            cnt_reg    <= cnt_next;
            kind_reg   <= kind_next;
        end
        okind_reg <= okind_next;
        ofree_reg <= ofree_next;
        oslot_reg <= oslot_next;
    end

    assign out_valid = ovalid_reg;
    assign out_kind  = okind_reg;
    assign out_free  = ofree_reg;
    assign out_slot  = oslot_reg;

endmodule

// ----- sv/rscc_datapath.sv -----
// ----------------------------------------------------------------------------
// rscc_datapath
// obstacle memory, cordic rotation unit and pipelined intersection test
// ----------------------------------------------------------------------------
module rscc_datapath #(
    parameter int MAX_OBSTACLES = rscc_pkg::DEF_MAX_OBSTACLES,
    parameter int COORD_BITS    = rscc_pkg::DEF_COORD_BITS,
    parameter int AW            = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rscc_pkg::rscc_cmd_t               cmd,
    input  logic [AW-1:0]                     scan_addr,
    output rscc_pkg::rscc_status_t            status,
    input  logic [rscc_pkg::SLOT_W-1:0]       in_slot,
    input  logic signed [COORD_BITS-1:0]      in_pos_x,
    input  logic signed [COORD_BITS-1:0]      in_pos_y,
    input  logic signed [COORD_BITS-1:0]      in_end_x,
    input  logic signed [COORD_BITS-1:0]      in_end_y,
    input  logic signed [rscc_pkg::HEADING_W-1:0] in_heading,
    input  logic [rscc_pkg::LEN_W-1:0]        segment_length
);

    localparam int W    = COORD_BITS;
    localparam int DW   = W + 1;
    localparam int DL_W = rscc_pkg::DL_W;
    localparam int Z_W  = rscc_pkg::Z_W;
    localparam int PA_W = DW + DL_W;
    localparam int PB_W = 2 * DW;
    localparam int CW   = ((PA_W > PB_W) ? PA_W : PB_W) + 1;
    localparam int EW   = 4 * W;

    // obstacle table: {end_y, end_x, start_y, start_x}
    logic [EW-1:0] mem [MAX_OBSTACLES];
    logic [EW-1:0] rd_reg;

    logic signed [W-1:0]                   px_reg, py_reg;
    logic [rscc_pkg::HEADING_W-1:0]        hd_reg;
    logic signed [DL_W-1:0]                x_reg, y_reg;
    logic signed [Z_W-1:0]                 z_reg;

    // pipeline stage valids and index
    logic [4:0]                            v_reg;
    logic [AW-1:0]                         idx_reg, i1_reg, i2_reg, i3_reg, i4_reg;

    logic signed [DW-1:0]   rx_reg, ry_reg, qx_reg, qy_reg;
    logic signed [PA_W-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [PB_W-1:0] m5_reg, m6_reg;
    logic signed [CW-1:0]   den_reg, tn_reg, un_reg;
    logic signed [CW-1:0]   dena_reg, tna_reg, una_reg;
    logic                   dz_reg;
    logic                   found_reg;
    logic [rscc_pkg::SLOT_W-1:0] hslot_reg;

    logic [31:0]            zu, zs;
    logic                   flip;
    logic [62:0]            gain_prod;
    logic signed [DL_W-1:0] x0;
    logic signed [DL_W-1:0] xs, ys;
    logic signed [Z_W-1:0]  at;
    logic signed [W-1:0]    ax, ay, bx, by;
    logic                   hit;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[AW'(in_slot)] <= {in_end_y, in_end_x, in_pos_y, in_pos_x};
        end
        if (cmd.scan_issue) begin
            rd_reg  <= mem[scan_addr];
            idx_reg <= scan_addr;
        end
    end

    // cordic: start vector, then one micro-rotation per cycle
    assign zu        = {hd_reg, 16'h0000};
    assign flip      = zu[31] ^ zu[30];
    assign zs        = flip ? (zu ^ 32'h8000_0000) : zu;
    assign gain_prod = 63'(segment_length) * 63'(rscc_pkg::CORDIC_GAIN_Q32);
    assign x0        = DL_W'($signed({1'b0, gain_prod[62:32]}));
    assign xs        = x_reg >>> cmd.step;
    assign ys        = y_reg >>> cmd.step;
    assign at        = $signed({{(Z_W-32){1'b0}}, rscc_pkg::cordic_atan(cmd.step)});

    always_ff @(posedge aclk) begin
        if (cmd.q_load) begin
            px_reg <= in_pos_x;
            py_reg <= in_pos_y;
            hd_reg <= in_heading;
        end
        if (cmd.cordic_init) begin
            x_reg <= flip ? -x0 : x0;
            y_reg <= '0;
            z_reg <= Z_W'($signed(zs));
        end else if (cmd.cordic_step) begin
            if (!z_reg[Z_W-1]) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign ax = rd_reg[W-1:0];
    assign ay = rd_reg[2*W-1:W];
    assign bx = rd_reg[3*W-1:2*W];
    assign by = rd_reg[4*W-1:3*W];

    assign hit = v_reg[4] && !dz_reg && !tna_reg[CW-1] && (tna_reg <= dena_reg)
                 && !una_reg[CW-1] && (una_reg <= dena_reg);

    // intersection pipeline: differences, products, crosses, sign fix, compare
    always_ff @(posedge aclk) begin
        rx_reg <= DW'(bx) - DW'(ax);
        ry_reg <= DW'(by) - DW'(ay);
        qx_reg <= DW'(px_reg) - DW'(ax);
        qy_reg <= DW'(py_reg) - DW'(ay);
        i1_reg <= idx_reg;
        i2_reg <= i1_reg;

        m1_reg <= rx_reg * y_reg;
        m2_reg <= ry_reg * x_reg;
        m3_reg <= qx_reg * y_reg;
        m4_reg <= qy_reg * x_reg;
        m5_reg <= qx_reg * ry_reg;
        m6_reg <= qy_reg * rx_reg;
        i3_reg <= i2_reg;

        den_reg <= CW'(m1_reg) - CW'(m2_reg);
        tn_reg  <= CW'(m3_reg) - CW'(m4_reg);
        un_reg  <= CW'(m5_reg) - CW'(m6_reg);
        i4_reg  <= i3_reg;

        dz_reg   <= (den_reg == '0);
        dena_reg <= den_reg[CW-1] ? -den_reg : den_reg;
        tna_reg  <= den_reg[CW-1] ? -tn_reg  : tn_reg;
        una_reg  <= den_reg[CW-1] ? -un_reg  : un_reg;

        if (!found_reg && hit) begin
            hslot_reg <= rscc_pkg::SLOT_W'(i4_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg     <= '0;
            found_reg <= 1'b0;
        end else begin
            v_reg <= {v_reg[3:0], cmd.scan_issue};
            if (cmd.q_load) begin
                found_reg <= 1'b0;
            end else if (hit) begin
                found_reg <= 1'b1;
            end
        end
    end

    assign status.pipe_busy = |v_reg;
    assign status.hit_found = found_reg;
    assign status.hit_slot  = hslot_reg;

endmodule

// ----- sv/rotated_segment_collision_check.sv -----
// ----------------------------------------------------------------------------
// rotated_segment_collision_check
// body segment versus obstacle table collision test
// ----------------------------------------------------------------------------
// A write beat (tuser 0) stores one obstacle segment at a table slot and is
// answered once the output register is free; the block is ready for the next
// beat as soon as that answer is registered. A query beat (tuser 1) builds a
// body segment of segment_length from the pose along the heading with a
// 16-step cordic (one micro-rotation per cycle), then streams table entries
// 0..min(obstacle_count, MAX_OBSTACLES)-1 through a pipelined exact
// cross-product test, one entry per cycle from the obstacle memory. Once the
// last entry has left the pipeline the query answer is registered and the
// block is ready for the next beat; parallel and degenerate pairs count as
// no hit. The answer carries is_free and the index of the first obstacle hit.
// One item is worked on at a time; a finished answer waits in the output
// register while the next beat is accepted.
// ----------------------------------------------------------------------------
module rotated_segment_collision_check #(
    parameter int MAX_OBSTACLES = rscc_pkg::DEF_MAX_OBSTACLES,
    parameter int COORD_BITS    = rscc_pkg::DEF_COORD_BITS,
    parameter int IN_BITS       = rscc_pkg::SLOT_W + 4 * COORD_BITS + rscc_pkg::HEADING_W,
    parameter int IN_W          = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // slot, pos_x, pos_y, end_x, end_y, heading, zero fill
    input  logic [IN_W-1:0]                   s_tdata,
    // cmd
    input  logic                              s_tuser,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // is_free, hit_slot, zero fill
    output logic [7:0]                        m_tdata,
    // kind
    output logic                              m_tuser,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rscc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rscc_pkg::CFG_DAT_W-1:0]    cfg_data
);

    localparam int W  = COORD_BITS;
    localparam int SW = rscc_pkg::SLOT_W;
    localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;

    logic [rscc_pkg::LEN_W-1:0]   seg_len_reg;
    logic [rscc_pkg::COUNT_W-1:0] obs_cnt_reg;

    // unpacked input fields
    logic [SW-1:0]                       f_slot;
    logic signed [W-1:0]                 f_pos_x, f_pos_y, f_end_x, f_end_y;
    logic signed [rscc_pkg::HEADING_W-1:0] f_heading;

    rscc_pkg::rscc_cmd_t    cmd;
    rscc_pkg::rscc_status_t status;
    logic [AW-1:0]          scan_addr;
    logic                   out_free;
    logic [SW-1:0]          out_slot;

    assign f_slot    = s_tdata[SW-1:0];
    assign f_pos_x   = s_tdata[SW+W-1:SW];
    assign f_pos_y   = s_tdata[SW+2*W-1:SW+W];
    assign f_end_x   = s_tdata[SW+3*W-1:SW+2*W];
    assign f_end_y   = s_tdata[SW+4*W-1:SW+3*W];
    assign f_heading = s_tdata[IN_BITS-1:SW+4*W];

    // registers are always writable; software must write them only while idle, which the block leaves unchecked
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_len_reg <= rscc_pkg::LEN_W'(65536);
            obs_cnt_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rscc_pkg::CFG_SEGMENT_LENGTH: seg_len_reg <= cfg_data[rscc_pkg::LEN_W-1:0];
                rscc_pkg::CFG_OBSTACLE_COUNT: obs_cnt_reg <= cfg_data[rscc_pkg::COUNT_W-1:0];
                default: ;  // unknown index ignored
            endcase
        end
    end

    rscc_ctrl #(
        .MAX_OBSTACLES (MAX_OBSTACLES),
        .AW            (AW)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_cmd         (s_tuser),
        .in_slot        (f_slot),
        .obstacle_count (obs_cnt_reg),
        .cmd            (cmd),
        .scan_addr      (scan_addr),
        .status         (status),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_kind       (m_tuser),
        .out_free       (out_free),
        .out_slot       (out_slot)
    );

    rscc_datapath #(
        .MAX_OBSTACLES (MAX_OBSTACLES),
        .COORD_BITS    (COORD_BITS),
        .AW            (AW)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .scan_addr      (scan_addr),
        .status         (status),
        .in_slot        (f_slot),
        .in_pos_x       (f_pos_x),
        .in_pos_y       (f_pos_y),
        .in_end_x       (f_end_x),
        .in_end_y       (f_end_y),
        .in_heading     (f_heading),
        .segment_length (seg_len_reg)
    );

    assign m_tdata = {1'b0, out_slot, out_free};

endmodule

// ----- sv/rscc_checker.sv -----
// ----------------------------------------------------------------------------
// rscc_checker
// port-level checks of the collision checker, bound to the top level
// ----------------------------------------------------------------------------
module rscc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // one item at a time: busy right after an accepted beat
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat accepted while busy");

    // acknowledge carries fixed fields
    a_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 8'h00)
        else $error("write acknowledge with nonzero data");

    // free answer carries slot zero
    a_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[7:1] == 7'd0)
        else $error("free answer with nonzero slot");

endmodule

bind rotated_segment_collision_check rscc_checker u_rscc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- verif/rotated_segment_collision_check_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotated_segment_collision_check_tb
// self-checking bench for the body segment versus obstacle table checker
// ----------------------------------------------------------------------------
// Obstacle writes and pose queries are streamed in with random gaps while the
// result side stalls at random. Every accepted beat is run through a local
// cordic and exact cross-product predictor and the expected answer is queued;
// each result beat is compared against the oldest queued answer.
// ----------------------------------------------------------------------------
module rotated_segment_collision_check_tb;

    localparam int TABLE_DEPTH = 64;
    localparam logic [rscc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'd5;

    // arctangent per micro-rotation, binary angle with 2^32 per turn
    localparam logic [31:0] ROT_ANGLE [16] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
    };

    typedef struct packed {
        logic       kind;
        logic       is_free;
        logic [5:0] hit_slot;
    } answer_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;
    logic         m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [rscc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rscc_pkg::CFG_DAT_W-1:0] cfg_data;

    rotated_segment_collision_check i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // slot, pos_x, pos_y, end_x, end_y, heading, zero fill
        .s_tuser   (s_tuser),   // cmd
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // is_free, hit_slot, zero fill
        .m_tuser   (m_tuser),   // kind
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state: obstacle table and the two registers
    longint      obs_ax [TABLE_DEPTH];
    longint      obs_ay [TABLE_DEPTH];
    longint      obs_bx [TABLE_DEPTH];
    longint      obs_by [TABLE_DEPTH];
    logic [30:0] body_len;
    logic [6:0]  scan_count;

    answer_t     pending_answers [$];
    int          mismatches;
    int          n_queries;
    int          n_blocked;
    int          n_writes;
    bit          tx_calm;
    bit          rx_calm;
    int          rx_hold;
    int          rx_stall;

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // coordinates mostly within +-8.0 so that segments cross, some full range
    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $urandom_range(0, 1048575) - 524288;
    endfunction

    // body vector from heading: quadrant fold, gain-compensated start, 16 steps
    function automatic void body_vector(input logic [15:0] hd, output longint vx,
                                        output longint vy);
        logic [31:0] ang;
        logic [63:0] prod;
        longint      z;
        longint      xs;
        longint      ys;
        ang  = {hd, 16'h0000};
        prod = {33'b0, body_len} * 64'h0000_0000_9B74_EDA8;
        vx   = longint'(prod[63:32]);
        vy   = 0;
        if (ang[31:30] == 2'b01 || ang[31:30] == 2'b10) begin
            ang = ang - 32'h8000_0000;
            vx  = -vx;
        end
        z = longint'($signed(ang));
        for (int i = 0; i < 16; i++) begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (z >= 0) begin
                vx = vx - ys;
                vy = vy + xs;
                z  = z - longint'(ROT_ANGLE[i]);
            end else begin
                vx = vx + ys;
                vy = vy - xs;
                z  = z + longint'(ROT_ANGLE[i]);
            end
        end
    endfunction

    // exact segment crossing, inclusive ends, parallel counts as clear
    function automatic bit segments_cross(input longint ax, input longint ay,
                                          input longint bx, input longint by,
                                          input longint cx, input longint cy,
                                          input longint dx, input longint dy);
        logic signed [127:0] rx, ry, sx, sy, qx, qy, den, tn, un;
        rx = bx - ax;
        ry = by - ay;
        sx = dx - cx;
        sy = dy - cy;
        qx = cx - ax;
        qy = cy - ay;
        den = rx * sy - ry * sx;
        if (den == 0) return 1'b0;
        tn = qx * sy - qy * sx;
        un = qx * ry - qy * rx;
        if (den < 0) begin
            den = -den;
            tn  = -tn;
            un  = -un;
        end
        return tn >= 0 && tn <= den && un >= 0 && un <= den;
    endfunction

    // update the table or answer the query, returning the expected result
    function automatic answer_t collision_answer(input logic cmd, input logic [5:0] slot,
                                                 input logic [31:0] px, input logic [31:0] py,
                                                 input logic [31:0] ex, input logic [31:0] ey,
                                                 input logic [15:0] hd);
        answer_t a;
        longint  sx, sy, vx, vy;
        int      n;
        sx = longint'($signed(px));
        sy = longint'($signed(py));
        if (cmd == rscc_pkg::CMD_WRITE) begin
            obs_ax[slot] = sx;
            obs_ay[slot] = sy;
            obs_bx[slot] = longint'($signed(ex));
            obs_by[slot] = longint'($signed(ey));
            a = '{rscc_pkg::KIND_WRITE_ACK, 1'b0, 6'd0};
            return a;
        end
        body_vector(hd, vx, vy);
        n = (scan_count > TABLE_DEPTH) ? TABLE_DEPTH : scan_count;
        a = '{rscc_pkg::KIND_QUERY, 1'b1, 6'd0};
        for (int i = 0; i < n; i++) begin
            if (segments_cross(obs_ax[i], obs_ay[i], obs_bx[i], obs_by[i],
                               sx, sy, sx + vx, sy + vy)) begin
                a.is_free  = 1'b0;
                a.hit_slot = i[5:0];
                break;
            end
        end
        return a;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // one beat on the input stream; called at a falling edge, returns at one
    task automatic send_item(input logic cmd, input logic [5:0] slot,
                             input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] ex, input logic [31:0] ey,
                             input logic [15:0] hd);
        int gap;
        answer_t a;
        gap = tx_calm ? 0 : rand_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {2'b00, hd, ey, ex, py, px, slot};
        do @(posedge aclk); while (!s_tready);
        a = collision_answer(cmd, slot, px, py, ex, ey, hd);
        pending_answers.push_back(a);
        if (cmd == rscc_pkg::CMD_QUERY) n_queries++;
        else n_writes++;
        @(negedge aclk);
    endtask

    task automatic send_write(input logic [5:0] slot, input logic [31:0] ax, input logic [31:0] ay,
                              input logic [31:0] bx, input logic [31:0] by);
        send_item(rscc_pkg::CMD_WRITE, slot, ax, ay, bx, by, 16'($urandom));
    endtask

    task automatic send_query(input logic [31:0] px, input logic [31:0] py, input logic [15:0] hd);
        send_item(rscc_pkg::CMD_QUERY, 6'($urandom), px, py, $urandom, $urandom, hd);
    endtask

    // wait until every answer is back, then leave a margin before returning
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending_answers.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // register write, only issued while the block is idle
    task automatic write_reg(input logic [rscc_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == rscc_pkg::CFG_SEGMENT_LENGTH) body_len = val[30:0];
        else if (idx == rscc_pkg::CFG_OBSTACLE_COUNT) scan_count = val[6:0];
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // receiver: random stalls plus a long hold-off on request
    initial begin
        m_tready = 1'b0;
        rx_stall = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_tready = 1'b0;
                rx_hold--;
            end else if (rx_stall > 0) begin
                m_tready = 1'b0;
                rx_stall--;
            end else begin
                m_tready = 1'b1;
                if (!rx_calm) rx_stall = rand_gap();
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        answer_t exp_a;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                exp_a = pending_answers.pop_front();
                if (m_tuser !== exp_a.kind)
                    report_mismatch($sformatf("kind %b, expected %b", m_tuser, exp_a.kind));
                if (m_tdata[0] !== exp_a.is_free)
                    report_mismatch($sformatf("is_free %b, expected %b",
                                              m_tdata[0], exp_a.is_free));
                if (m_tdata[6:1] !== exp_a.hit_slot)
                    report_mismatch($sformatf("hit_slot %0d, expected %0d",
                                              m_tdata[6:1], exp_a.hit_slot));
                if (exp_a.kind == rscc_pkg::KIND_QUERY && !exp_a.is_free) n_blocked++;
            end
        end
    end

    // extremes of every field and each special case
    task automatic test_directed();
        tx_calm = 1'b0;
        // no obstacles checked: always free
        send_query(32'h0, 32'h0, 16'h0000);
        // vertical wall at x=0.5 crossing the +x body segment
        send_write(6'd0, 32'h0000_8000, 32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000);
        // extreme coordinates
        send_write(6'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        // zero-length obstacle
        send_write(6'd2, 32'h0000_4000, 32'h0000_0000, 32'h0000_4000, 32'h0000_0000);
        // collinear with a pose on the x axis
        send_write(6'd3, 32'hFFFF_0000, 32'h0000_0000, 32'h0002_0000, 32'h0000_0000);
        // horizontal wall at y=0.5
        send_write(6'd63, 32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000, 32'h0000_8000);
        send_write(6'd4, 32'h0000_0000, 32'h0000_8000, 32'h0000_0000, 32'h0000_8000);
        drain();
        write_reg(rscc_pkg::CFG_OBSTACLE_COUNT, 32'd5);
        write_reg(rscc_pkg::CFG_SEGMENT_LENGTH, 32'h0001_0000);
        send_query(32'h0, 32'h0, 16'h0000);
        send_query(32'h0, 32'h0, 16'h4000);
        send_query(32'h0, 32'h0, 16'h8000);
        send_query(32'h0, 32'h0, 16'h7FFF);
        send_query(32'h0, 32'h0, 16'hC000);
        send_query(32'h7FFF_FFFF, 32'h8000_0000, 16'hA000);
        send_query(32'h8000_0000, 32'h7FFF_FFFF, 16'h2000);
        drain();
        // zero length: every pair degenerate
        write_reg(rscc_pkg::CFG_SEGMENT_LENGTH, 32'h0);
        write_reg(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
        send_query(32'hFFFF_C000, 32'h0, 16'h0000);
        drain();
        write_reg(rscc_pkg::CFG_SEGMENT_LENGTH, 32'h7FFF_FFFF);
        send_query(32'hFFFF_C000, 32'h0, 16'h0000);
        send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000);
        drain();
    endtask

    // every slot written, then phases of mixed traffic under varied settings
    task automatic test_random_traffic();
        logic [31:0] len;
        logic [31:0] cnt;
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_write(i[5:0], rand_coord(), rand_coord(), rand_coord(), rand_coord());
        for (int ph = 0; ph < 7; ph++) begin
            drain();
            case (ph)
                0:       len = 32'h0002_0000;
                1:       len = 32'h7FFF_FFFF;
                2:       len = 32'h0;
                default: len = $urandom_range(32'h0000_4000, 32'h0006_0000);
            endcase
            case (ph)
                1:       cnt = 32'd127;
                2:       cnt = 32'd0;
                3:       cnt = 32'd64;
                default: cnt = $urandom_range(1, 64);
            endcase
            if (ph == 5) cnt = 32'hFFFF_FF40;  // upper bits dropped, count 64
            write_reg(rscc_pkg::CFG_SEGMENT_LENGTH, len);
            write_reg(rscc_pkg::CFG_OBSTACLE_COUNT, cnt);
            tx_calm = (ph == 4);
            rx_calm = (ph == 4);
            for (int k = 0; k < 100; k++) begin
                if ($urandom_range(0, 3) == 0)
                    send_write(6'($urandom), rand_coord(), rand_coord(), rand_coord(),
                               rand_coord());
                else
                    send_query(rand_coord(), rand_coord(), 16'($urandom));
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        drain();
    endtask

    // long receiver hold-off while the sender keeps offering beats
    task automatic test_backpressure();
        write_reg(rscc_pkg::CFG_SEGMENT_LENGTH, 32'h0003_0000);
        write_reg(rscc_pkg::CFG_OBSTACLE_COUNT, 32'd16);
        tx_calm = 1'b1;
        rx_hold = 400;
        for (int k = 0; k < 30; k++)
            send_query(rand_coord(), rand_coord(), 16'($urandom));
        tx_calm = 1'b0;
        drain();
    endtask

    initial begin
        int waited;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tuser    = rscc_pkg::CMD_WRITE;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = rscc_pkg::CFG_SEGMENT_LENGTH;
        cfg_data   = '0;
        mismatches = 0;
        n_queries  = 0;
        n_blocked  = 0;
        n_writes   = 0;
        tx_calm    = 1'b0;
        rx_calm    = 1'b0;
        rx_hold    = 0;
        body_len   = 31'h0001_0000;
        scan_count = 7'd0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            obs_ax[i] = 0;
            obs_ay[i] = 0;
            obs_bx[i] = 0;
            obs_by[i] = 0;
        end
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_directed();
        test_random_traffic();
        test_backpressure();

        waited = 0;
        while (pending_answers.size() != 0 && waited < 100000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (200) @(negedge aclk);
        $display("covered %0d obstacle writes and %0d pose queries, %0d of them blocked",
                 n_writes, n_queries, n_blocked);
        $display("left over: %0d answers, mismatches: %0d", pending_answers.size(), mismatches);
        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
